// ===== sv/smbrp_pkg.sv =====
`timescale 1ns / 1ps

package smbrp_pkg;

  localparam int PoolDepth = 16;
  localparam int CntW      = $clog2(PoolDepth + 1);
  localparam int SizeW     = 32;
  localparam int HandleW   = 32;
  localparam int CmdW      = 2;
  localparam int ActW      = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_PURGE   = 2'd2
  } cmd_e;

  typedef enum logic [ActW-1:0] {
    ACT_HIT    = 3'd0,
    ACT_MISS   = 3'd1,
    ACT_STORED = 3'd2,
    ACT_FREE   = 3'd3,
    ACT_PURGED = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_EVICT,
    ST_STORE,
    ST_REL_FREE,
    ST_PURGE
  } state_e;

  typedef struct packed {
    logic capture;
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== sv/smbrp_cell.sv =====
`timescale 1ns / 1ps

module smbrp_cell (
  input  logic                          clk_i,
  input  smbrp_pkg::cell_ctrl_t         ctrl_i,
  input  logic                          live_i,
  input  logic                          seen_i,
  input  logic [smbrp_pkg::SizeW-1:0]   cmp_size_i,
  input  logic [smbrp_pkg::SizeW-1:0]   new_size_i,
  input  logic [smbrp_pkg::HandleW-1:0] new_handle_i,
  input  logic [smbrp_pkg::SizeW-1:0]   nbr_size_i,
  input  logic [smbrp_pkg::HandleW-1:0] nbr_handle_i,
  output logic [smbrp_pkg::SizeW-1:0]   size_o,
  output logic [smbrp_pkg::HandleW-1:0] handle_o,
  output logic                          seen_o,
  output logic                          hit_o
);
  import smbrp_pkg::*;

  logic [SizeW-1:0]   size_q;
  logic [HandleW-1:0] handle_q;
  logic               match_q;

  // shift takes the younger neighbor's entry, load appends a new one
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      size_q   <= nbr_size_i;
      handle_q <= nbr_handle_i;
    end else if (ctrl_i.load) begin
      size_q   <= new_size_i;
      handle_q <= new_handle_i;
    end
    if (ctrl_i.capture) begin
      match_q <= (size_q == cmp_size_i);
    end
  end

  // first live match wins; the chain tells younger cells a hit was seen
  assign hit_o    = match_q & live_i & ~seen_i;
  assign seen_o   = seen_i | hit_o;
  assign size_o   = size_q;
  assign handle_o = handle_q;

endmodule

// ===== sv/size_matched_block_recycle_pool_top.sv =====
`timescale 1ns / 1ps
// allocate: busy for one cycle, result registered from the alloc state, next accept at its transfer edge
// release: one result (stored, or free when disabled), or two (free oldest, stored) when full
// purge: one free per held entry, one per cycle, then purge done; busy until purge done is registered
// each result is strobed for one cycle; the receiver cannot stall
// reset empties the pool and enables it; entry contents need no clearing
module size_matched_block_recycle_pool_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [smbrp_pkg::CmdW-1:0]    command_i,
  input  logic [smbrp_pkg::SizeW-1:0]   request_size_i,
  input  logic [smbrp_pkg::HandleW-1:0] block_handle_i,
  output logic                          result_valid_o,
  output logic [smbrp_pkg::ActW-1:0]    action_o,
  output logic [smbrp_pkg::HandleW-1:0] handle_o,
  output logic                          last_o
);
  import smbrp_pkg::*;

  // sequencer state
  state_e state_q, state_d;

  // latched command payload, used by store and pass-through free
  logic [SizeW-1:0]   size_q;
  logic [HandleW-1:0] handle_q;

  // fill level of the cell row and the enable flag
  logic [CntW-1:0] count_q, count_d;
  logic            enabled_q, enabled_d;

  // registered result transfer
  logic               res_valid_q, res_valid_d;
  logic [ActW-1:0]    res_action_q, res_action_d;
  logic [HandleW-1:0] res_handle_q, res_handle_d;
  logic               res_last_q, res_last_d;

  // cell row wiring
  cell_ctrl_t         ctrl   [PoolDepth];
  logic               live   [PoolDepth];
  logic               seen   [PoolDepth];
  logic               hit    [PoolDepth];
  logic [SizeW-1:0]   c_size [PoolDepth];
  logic [HandleW-1:0] c_hnd  [PoolDepth];

  logic               accept;
  logic               hit_any;
  logic [HandleW-1:0] hit_handle;
  logic               shift_all;
  logic               shift_hit;
  logic               load_new;

  assign accept  = start_i & ~busy_o;
  assign busy_o  = (state_q != ST_IDLE);
  assign hit_any = seen[PoolDepth-1];

  // one-hot select of the matching cell's handle
  always_comb begin
    hit_handle = '0;
    for (int i = 0; i < PoolDepth; i++) begin
      hit_handle = hit_handle | ({HandleW{hit[i]}} & c_hnd[i]);
    end
  end

  // cell row: cell 0 holds the oldest entry
  for (genvar g = 0; g < PoolDepth; g++) begin : g_cell
    logic [SizeW-1:0]   nbr_size;
    logic [HandleW-1:0] nbr_hnd;
    logic               seen_in;

    if (g == PoolDepth - 1) begin : g_end
      assign nbr_size = '0;
      assign nbr_hnd  = '0;
    end else begin : g_mid
      assign nbr_size = c_size[g+1];
      assign nbr_hnd  = c_hnd[g+1];
    end

    if (g == 0) begin : g_head
      assign seen_in = 1'b0;
    end else begin : g_tail
      assign seen_in = seen[g-1];
    end

    assign live[g]         = (CntW'(g) < count_q);
    assign ctrl[g].capture = accept;
    // on a hit, the hit cell and every younger one take their neighbor's entry
    assign ctrl[g].shift   = shift_all | (shift_hit & seen[g]);
    assign ctrl[g].load    = load_new & (CntW'(g) == count_q);

    smbrp_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[g]),
      .live_i       (live[g]),
      .seen_i       (seen_in),
      .cmp_size_i   (request_size_i),
      .new_size_i   (size_q),
      .new_handle_i (handle_q),
      .nbr_size_i   (nbr_size),
      .nbr_handle_i (nbr_hnd),
      .size_o       (c_size[g]),
      .handle_o     (c_hnd[g]),
      .seen_o       (seen[g]),
      .hit_o        (hit[g])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (command_i)
            CMD_ALLOC: state_d = ST_ALLOC;
            CMD_RELEASE: begin
              if (!enabled_q) begin
                state_d = ST_REL_FREE;
              end else if (count_q == CntW'(PoolDepth)) begin
                state_d = ST_EVICT;
              end else begin
                state_d = ST_STORE;
              end
            end
            CMD_PURGE: state_d = ST_PURGE;
            default:   state_d = ST_IDLE; // unused code: dropped
          endcase
        end
      end
      ST_ALLOC:    state_d = ST_IDLE;
      ST_EVICT:    state_d = ST_STORE;
      ST_STORE:    state_d = ST_IDLE;
      ST_REL_FREE: state_d = ST_IDLE;
      ST_PURGE: begin
        if (count_q == '0) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath control and result generation
  always_comb begin
    count_d      = count_q;
    enabled_d    = enabled_q;
    shift_all    = 1'b0;
    shift_hit    = 1'b0;
    load_new     = 1'b0;
    res_valid_d  = 1'b0;
    res_action_d = ACT_MISS;
    res_handle_d = '0;
    res_last_d   = 1'b0;
    case (state_q)
      ST_ALLOC: begin
        // a disabled pool is empty, so this reports a miss there too
        res_valid_d = 1'b1;
        res_last_d  = 1'b1;
        if (hit_any) begin
          shift_hit    = 1'b1;
          count_d      = count_q - CntW'(1);
          res_action_d = ACT_HIT;
          res_handle_d = hit_handle;
        end else begin
          res_action_d = ACT_MISS;
        end
      end
      ST_EVICT: begin
        // pool full: free the oldest block, make room at the young end
        shift_all    = 1'b1;
        count_d      = count_q - CntW'(1);
        res_valid_d  = 1'b1;
        res_action_d = ACT_FREE;
        res_handle_d = c_hnd[0];
      end
      ST_STORE: begin
        load_new     = 1'b1;
        count_d      = count_q + CntW'(1);
        res_valid_d  = 1'b1;
        res_action_d = ACT_STORED;
        res_last_d   = 1'b1;
      end
      ST_REL_FREE: begin
        res_valid_d  = 1'b1;
        res_action_d = ACT_FREE;
        res_handle_d = handle_q;
        res_last_d   = 1'b1;
      end
      ST_PURGE: begin
        res_valid_d = 1'b1;
        if (count_q != '0) begin
          // drain oldest first, one entry per cycle
          shift_all    = 1'b1;
          count_d      = count_q - CntW'(1);
          res_action_d = ACT_FREE;
          res_handle_d = c_hnd[0];
        end else begin
          enabled_d    = 1'b0;
          res_action_d = ACT_PURGED;
          res_last_d   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      enabled_q   <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      enabled_q   <= enabled_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      size_q   <= request_size_i;
      handle_q <= block_handle_i;
    end
    res_action_q <= res_action_d;
    res_handle_q <= res_handle_d;
    res_last_q   <= res_last_d;
  end

  assign result_valid_o = res_valid_q;
  assign action_o       = res_action_q;
  assign handle_o       = res_handle_q;
  assign last_o         = res_last_q;

endmodule

// ===== bench/size_matched_block_recycle_pool_top_test.sv =====
`timescale 1ns / 1ps

module size_matched_block_recycle_pool_top_test;
  import smbrp_pkg::*;

  // command code that the block must swallow without any result
  localparam logic [CmdW-1:0] CmdUnused = 2'd3;
  // worst case is far below this: ~190 transfers, at most 17 results each
  localparam int CycleLimit  = 200000;
  // quiet cycles after the last expected result, to catch stray strobes
  localparam int DrainCycles = 24;

  // one expected result of the pool
  typedef struct {
    action_e            action;
    logic [HandleW-1:0] handle;
    logic               last;
  } pool_result_t;

  // shadow copy of the pool contents plus the queue of results still owed
  class recycle_pool_mirror;
    logic [SizeW-1:0]   held_size[PoolDepth];
    logic [HandleW-1:0] held_handle[PoolDepth];
    int                 held_count;
    bit                 pool_enabled = 1'b1;
    pool_result_t       pending_results[$];
    int                 mismatch_count;
    int                 checked_count;
    int                 hit_count;
    int                 evict_count;
    int                 transfer_count[4];

    task report(string msg);
      mismatch_count++;
      $display("%0t mismatch: %s", $realtime, msg);
    endtask

    function void push_result(action_e action, logic [HandleW-1:0] handle, logic last);
      pool_result_t r;
      r.action = action;
      r.handle = handle;
      r.last   = last;
      pending_results = {pending_results, r};
    endfunction

    // remove one entry and close the gap, keeping the age order
    function void drop_entry(int pos);
      for (int i = pos; i + 1 < held_count; i++) begin
        held_size[i]   = held_size[i + 1];
        held_handle[i] = held_handle[i + 1];
      end
      held_count--;
    endfunction

    // called once per accepted command transfer
    function void note_command(logic [CmdW-1:0] cmd, logic [SizeW-1:0] size,
                               logic [HandleW-1:0] hnd);
      int                 hit_pos;
      logic [HandleW-1:0] taken;
      hit_pos = -1;
      transfer_count[cmd]++;
      case (cmd)
        CMD_ALLOC: begin
          // scan from the newest down so the oldest exact match wins
          if (pool_enabled) begin
            for (int i = held_count - 1; i >= 0; i--) begin
              if (held_size[i] == size) hit_pos = i;
            end
          end
          if (hit_pos >= 0) begin
            taken = held_handle[hit_pos];
            drop_entry(hit_pos);
            hit_count++;
            push_result(ACT_HIT, taken, 1'b1);
          end else begin
            push_result(ACT_MISS, '0, 1'b1);
          end
        end
        CMD_RELEASE: begin
          if (!pool_enabled) begin
            // after a purge the block goes straight back to be freed
            push_result(ACT_FREE, hnd, 1'b1);
          end else begin
            if (held_count == PoolDepth) begin
              push_result(ACT_FREE, held_handle[0], 1'b0);
              drop_entry(0);
              evict_count++;
            end
            held_size[held_count]   = size;
            held_handle[held_count] = hnd;
            held_count++;
            push_result(ACT_STORED, '0, 1'b1);
          end
        end
        CMD_PURGE: begin
          pool_enabled = 1'b0;
          for (int i = 0; i < held_count; i++) push_result(ACT_FREE, held_handle[i], 1'b0);
          held_count = 0;
          push_result(ACT_PURGED, '0, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    // called once per strobed result
    task check_action(logic [ActW-1:0] action, logic [HandleW-1:0] handle, logic last);
      pool_result_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result action=%0d handle=%h last=%b",
                         action, handle, last));
        return;
      end
      want = pending_results.pop_front();
      checked_count++;
      if (action !== want.action)
        report($sformatf("action %0d, expected %0d", action, want.action));
      if (handle !== want.handle)
        report($sformatf("handle %h, expected %h (action %0d)", handle, want.handle,
                         want.action));
      if (last !== want.last)
        report($sformatf("last %b, expected %b (action %0d)", last, want.last, want.action));
    endtask
  endclass

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start_i        = 1'b0;
  logic [CmdW-1:0]      command_i      = '0;
  logic [SizeW-1:0]     request_size_i = '0;
  logic [HandleW-1:0]   block_handle_i = '0;
  logic                 busy_o;
  logic                 result_valid_o;
  logic [ActW-1:0]      action_o;
  logic [HandleW-1:0]   handle_o;
  logic                 last_o;

  recycle_pool_mirror   mirror;
  logic [SizeW-1:0]     size_menu[8];
  int                   cycle_count = 0;

  size_matched_block_recycle_pool_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .command_i      (command_i),
    .request_size_i (request_size_i),
    .block_handle_i (block_handle_i),
    .result_valid_o (result_valid_o),
    .action_o       (action_o),
    .handle_o       (handle_o),
    .last_o         (last_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("run stopped by watchdog at cycle %0d, %0d results still owed",
               cycle_count, mirror.pending_results.size());
      $display("[size_matched_block_recycle_pool_top] ERROR");
      $finish;
    end
  end

  // results are strobed for one cycle, sampled at the edge that ends it
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) mirror.check_action(action_o, handle_o, last_o);
  end

  // hold the command until a transfer edge (start high, busy low), then predict
  task automatic send_command(logic [CmdW-1:0] cmd, logic [SizeW-1:0] size,
                              logic [HandleW-1:0] hnd);
    start_i        <= 1'b1;
    command_i      <= cmd;
    request_size_i <= size;
    block_handle_i <= hnd;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    mirror.note_command(cmd, size, hnd);
  endtask

  // sender idles each cycle with the given chance in percent
  task automatic idle_gap(int pct);
    while ($urandom_range(0, 99) < pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // mostly a few recurring sizes so that allocations can hit
  function automatic logic [SizeW-1:0] pick_size();
    if ($urandom_range(0, 99) < 15) return $urandom;
    return size_menu[$urandom_range(0, 7)];
  endfunction

  task automatic send_random(int pct);
    int              r;
    logic [CmdW-1:0] cmd;
    r = $urandom_range(0, 99);
    if (r < 45)      cmd = CMD_ALLOC;
    else if (r < 95) cmd = CMD_RELEASE;
    else             cmd = CmdUnused;
    // purges only make sense once the pool is already disabled
    if (!mirror.pool_enabled && r >= 85 && r < 95) cmd = CMD_PURGE;
    idle_gap(pct);
    send_command(cmd, pick_size(), $urandom);
  endtask

  initial begin
    mirror = new();
    size_menu = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0040,
                  32'h0000_1000, 32'h8000_0000, $urandom, $urandom};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: miss on empty pool, size and handle extremes
    send_command(CMD_ALLOC, 32'h0000_0000, 32'hFFFF_FFFF);
    send_command(CMD_RELEASE, 32'h0000_0000, 32'h0000_0000);
    send_command(CMD_RELEASE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // two blocks of equal size, oldest must come back first
    send_command(CMD_RELEASE, 32'h0000_0005, 32'hA5A5_0001);
    send_command(CMD_RELEASE, 32'h0000_0005, 32'h5A5A_0002);
    send_command(CMD_ALLOC, 32'h0000_0005, 32'h0000_0000);
    send_command(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_ALLOC, 32'h0000_0000, 32'h0000_0000);
    // unused code, no result expected
    send_command(CmdUnused, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(CMD_ALLOC, 32'h0000_0005, 32'h0000_0000);
    // fill the pool, last release evicts the oldest entry
    for (int i = 0; i <= PoolDepth; i++) send_command(CMD_RELEASE, i, $urandom);

    // random traffic with the pool enabled, three sender idle profiles
    repeat (40) send_random(0);
    repeat (40) send_random(78);
    repeat (40) send_random(30);

    // top up to full so the purge drains every entry
    while (mirror.held_count < PoolDepth) begin
      idle_gap(30);
      send_command(CMD_RELEASE, pick_size(), $urandom);
    end
    send_command(CMD_PURGE, $urandom, $urandom);

    // disabled pool: pass-through frees, misses, purge of an empty pool
    send_command(CMD_RELEASE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_command(CMD_RELEASE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_command(CMD_ALLOC, 32'h0000_0000, 32'h0000_0000);
    send_command(CMD_PURGE, 32'h0000_0000, 32'h0000_0000);
    send_command(CmdUnused, 32'h0000_0000, 32'h0000_0000);
    repeat (20) send_random(30);

    // let every owed result arrive, then watch for stray strobes
    start_i <= 1'b0;
    while (mirror.pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("transfers: %0d allocate, %0d release, %0d purge, %0d unused code",
             mirror.transfer_count[CMD_ALLOC], mirror.transfer_count[CMD_RELEASE],
             mirror.transfer_count[CMD_PURGE], mirror.transfer_count[CmdUnused]);
    $display("results checked: %0d, reuse hits: %0d, evictions: %0d, mismatches: %0d",
             mirror.checked_count, mirror.hit_count, mirror.evict_count,
             mirror.mismatch_count);
    if (mirror.mismatch_count == 0) begin
      $display("[size_matched_block_recycle_pool_top] OK");
    end else begin
      $display("[size_matched_block_recycle_pool_top] ERROR");
    end
    $finish;
  end

endmodule
